FILE: rtl/sorted_alias_table_resolver_unit_defines.svh
// Assertion helpers for the files that check their own logic.
`ifndef SORTED_ALIAS_TABLE_RESOLVER_UNIT_DEFINES_SVH
`define SORTED_ALIAS_TABLE_RESOLVER_UNIT_DEFINES_SVH

// A condition that must hold in the same cycle as its trigger.
`define SAT_ASSERT_SAME(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define SAT_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

FILE: rtl/sat_pkg.sv
package sat_pkg;

    typedef enum logic [0:0] {
        OP_INSERT  = 1'b0,
        OP_RESOLVE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_MERGED  = 2'd0,
        KIND_RENAMED = 2'd1,
        KIND_SPLIT   = 2'd2,
        KIND_TOMB    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_TOMB      = 3'd3,
        ST_AMBIG     = 3'd4,
        ST_MERGED    = 3'd5,
        ST_RENAMED   = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_CHK,
        S_SRCH_CMP,
        S_SHIFT_CHK,
        S_SHIFT_WR,
        S_FIRST_CHK,
        S_RUN_CMP,
        S_EMIT_RD,
        S_EMIT_LD,
        S_OUT_WAIT
    } state_t;

    typedef struct packed {
        logic [63:0] key;
        logic [63:0] succ;
        kind_t       kind;
    } entry_t;

    localparam logic [8:0] RUN_LENGTH_MAX = 9'd511;

endpackage

FILE: rtl/sat_in_if.sv
interface sat_in_if;
    import sat_pkg::*;

    logic        valid;
    logic        ready;
    opcode_t     opcode;
    logic [63:0] old_id;
    logic [63:0] new_id;
    kind_t       alias_kind;

    modport source (output valid, output opcode, output old_id, output new_id,
                    output alias_kind, input ready);
    modport sink   (input valid, input opcode, input old_id, input new_id,
                    input alias_kind, output ready);
endinterface

FILE: rtl/sat_out_if.sv
interface sat_out_if;
    import sat_pkg::*;

    logic        valid;
    logic        ready;
    status_t     status;
    logic [63:0] target_id;
    logic [8:0]  run_length;
    logic        truncated;
    logic        last;

    modport source (output valid, output status, output target_id, output run_length,
                    output truncated, output last, input ready);
    modport sink   (input valid, input status, input target_id, input run_length,
                    input truncated, input last, output ready);
endinterface

FILE: rtl/sorted_alias_table_resolver_unit.sv
// Channel   Dir  Word fields
// in_item   in   opcode, old_id, new_id, alias_kind
// out_item  out  status, target_id, run_length, truncated, last
//
// One word at a time: in_item is ready only in the idle state.
// Each binary search step reads in S_SRCH_CHK and compares in S_SRCH_CMP, over the one read port and comparator.
// An insert then moves each later entry up, reading it in S_SHIFT_CHK and writing it in S_SHIFT_WR.
// A resolve scans the run in S_RUN_CMP; a split or multi-entry run fetches each successor in S_EMIT_RD, S_EMIT_LD.
// Every result word waits in an output register until out_item takes it.
// Reset empties the table at once; table contents need no clearing.
`include "sorted_alias_table_resolver_unit_defines.svh"

module sorted_alias_table_resolver_unit #(
    parameter int TABLE_DEPTH       = 256,
    parameter int MAX_SPLIT_RESULTS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    sat_in_if.sink     in_item,
    sat_out_if.source  out_item
);
    import sat_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int KW = $clog2(MAX_SPLIT_RESULTS + 1);
    localparam int RW = (CW > KW) ? CW : KW;
    localparam int SW = (CW > 9) ? CW : 9;

    state_t         state_reg, state_next;
    opcode_t        op_reg, op_next;
    logic [63:0]    key_reg, key_next;
    logic [63:0]    succ_reg, succ_next;
    kind_t          kind_reg, kind_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  lo_reg, lo_next;
    logic [CW-1:0]  hi_reg, hi_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [CW-1:0]  run_reg, run_next;
    kind_t          fk_reg, fk_next;
    logic [63:0]    succ0_reg, succ0_next;
    logic [KW-1:0]  k_reg, k_next;
    logic [KW-1:0]  n_reg, n_next;
    logic           trunc_reg, trunc_next;
    status_t        o_status_reg, o_status_next;
    logic [63:0]    o_target_reg, o_target_next;
    logic [8:0]     o_run_reg, o_run_next;
    logic           o_trunc_reg, o_trunc_next;
    logic           o_last_reg, o_last_next;

    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    entry_t         rd_data;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    entry_t         wr_data;
    logic           cmp_lt, cmp_eq;
    logic [CW-1:0]  mid;

    sat_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    sat_cmp u_cmp (
        .a  (rd_data.key),
        .b  (key_reg),
        .lt (cmp_lt),
        .eq (cmp_eq)
    );

    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    function automatic logic [8:0] sat_run(input logic [CW-1:0] r);
        logic [SW-1:0] ext;
        ext = SW'(r);
        if (ext > SW'(RUN_LENGTH_MAX))
        begin
            return RUN_LENGTH_MAX;
        end
        return ext[8:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        succ_reg     <= succ_next;
        kind_reg     <= kind_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        idx_reg      <= idx_next;
        run_reg      <= run_next;
        fk_reg       <= fk_next;
        succ0_reg    <= succ0_next;
        k_reg        <= k_next;
        n_reg        <= n_next;
        trunc_reg    <= trunc_next;
        o_status_reg <= o_status_next;
        o_target_reg <= o_target_next;
        o_run_reg    <= o_run_next;
        o_trunc_reg  <= o_trunc_next;
        o_last_reg   <= o_last_next;
    end

    always_comb
    begin
        logic          first;
        logic          decide;
        logic [CW-1:0] run_n;
        kind_t         fk_n;
        logic [63:0]   succ_n;
        logic          tr;

        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        succ_next     = succ_reg;
        kind_next     = kind_reg;
        count_next    = count_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        idx_next      = idx_reg;
        run_next      = run_reg;
        fk_next       = fk_reg;
        succ0_next    = succ0_reg;
        k_next        = k_reg;
        n_next        = n_reg;
        trunc_next    = trunc_reg;
        o_status_next = o_status_reg;
        o_target_next = o_target_reg;
        o_run_next    = o_run_reg;
        o_trunc_next  = o_trunc_reg;
        o_last_next   = o_last_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = rd_data;
        first         = 1'b0;
        decide        = 1'b0;
        run_n         = run_reg;
        fk_n          = fk_reg;
        succ_n        = succ0_reg;
        tr            = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_item.valid)
                begin
                    op_next   = in_item.opcode;
                    key_next  = in_item.old_id;
                    succ_next = in_item.new_id;
                    kind_next = in_item.alias_kind;
                    lo_next   = '0;
                    hi_next   = count_reg;
                    if (in_item.opcode == OP_INSERT && count_reg == CW'(TABLE_DEPTH))
                    begin
                        o_status_next = ST_FULL;
                        o_target_next = '0;
                        o_run_next    = '0;
                        o_trunc_next  = 1'b0;
                        o_last_next   = 1'b1;
                        state_next    = S_OUT_WAIT;
                    end
                    else
                    begin
                        state_next = S_SRCH_CHK;
                    end
                end
            end

            S_SRCH_CHK:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = mid[AW-1:0];
                    state_next = S_SRCH_CMP;
                end
                else if (op_reg == OP_INSERT)
                begin
                    idx_next   = count_reg;
                    state_next = S_SHIFT_CHK;
                end
                else
                begin
                    state_next = S_FIRST_CHK;
                end
            end

            S_SRCH_CMP:
            begin
                // Inserts search past equal keys so that equal keys keep their order.
                if (cmp_lt || (op_reg == OP_INSERT && cmp_eq))
                begin
                    lo_next = mid + CW'(1);
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = S_SRCH_CHK;
            end

            S_SHIFT_CHK:
            begin
                if (idx_reg > lo_reg)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(idx_reg - CW'(1));
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    wr_en         = 1'b1;
                    wr_addr       = lo_reg[AW-1:0];
                    wr_data.key   = key_reg;
                    wr_data.succ  = succ_reg;
                    wr_data.kind  = kind_reg;
                    count_next    = count_reg + CW'(1);
                    o_status_next = ST_INSERTED;
                    o_target_next = '0;
                    o_run_next    = '0;
                    o_trunc_next  = 1'b0;
                    o_last_next   = 1'b1;
                    state_next    = S_OUT_WAIT;
                end
            end

            S_SHIFT_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg[AW-1:0];
                idx_next   = idx_reg - CW'(1);
                state_next = S_SHIFT_CHK;
            end

            S_FIRST_CHK:
            begin
                if (lo_reg >= count_reg)
                begin
                    o_status_next = ST_NOT_FOUND;
                    o_target_next = '0;
                    o_run_next    = '0;
                    o_trunc_next  = 1'b0;
                    o_last_next   = 1'b1;
                    state_next    = S_OUT_WAIT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = lo_reg[AW-1:0];
                    idx_next   = lo_reg;
                    run_next   = '0;
                    state_next = S_RUN_CMP;
                end
            end

            S_RUN_CMP:
            begin
                first = (idx_reg == lo_reg);
                if (cmp_eq)
                begin
                    run_n = run_reg + CW'(1);
                    if (first)
                    begin
                        fk_n   = rd_data.kind;
                        succ_n = rd_data.succ;
                    end
                    run_next   = run_n;
                    fk_next    = fk_n;
                    succ0_next = succ_n;
                    idx_next   = idx_reg + CW'(1);
                    if ((idx_reg + CW'(1)) < count_reg)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(idx_reg + CW'(1));
                    end
                    else
                    begin
                        decide = 1'b1;
                    end
                end
                else
                begin
                    decide = 1'b1;
                end

                if (decide)
                begin
                    o_trunc_next = 1'b0;
                    o_last_next  = 1'b1;
                    o_run_next   = sat_run(run_n);
                    if (run_n == '0)
                    begin
                        o_status_next = ST_NOT_FOUND;
                        o_target_next = '0;
                        o_run_next    = '0;
                        state_next    = S_OUT_WAIT;
                    end
                    else if (fk_n == KIND_TOMB)
                    begin
                        o_status_next = ST_TOMB;
                        o_target_next = '0;
                        state_next    = S_OUT_WAIT;
                    end
                    else if (fk_n == KIND_SPLIT || run_n > CW'(1))
                    begin
                        tr         = RW'(run_n) > RW'(MAX_SPLIT_RESULTS);
                        trunc_next = tr;
                        n_next     = tr ? KW'(MAX_SPLIT_RESULTS) : KW'(run_n);
                        k_next     = '0;
                        state_next = S_EMIT_RD;
                    end
                    else
                    begin
                        o_status_next = (fk_n == KIND_RENAMED) ? ST_RENAMED : ST_MERGED;
                        o_target_next = succ_n;
                        state_next    = S_OUT_WAIT;
                    end
                end
            end

            S_EMIT_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = AW'(lo_reg + CW'(k_reg));
                state_next = S_EMIT_LD;
            end

            S_EMIT_LD:
            begin
                o_status_next = ST_AMBIG;
                o_target_next = rd_data.succ;
                o_run_next    = sat_run(run_reg);
                o_trunc_next  = trunc_reg;
                o_last_next   = ((k_reg + KW'(1)) == n_reg);
                k_next        = k_reg + KW'(1);
                state_next    = S_OUT_WAIT;
            end

            S_OUT_WAIT:
            begin
                if (out_item.ready)
                begin
                    state_next = o_last_reg ? S_IDLE : S_EMIT_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_item.ready       = (state_reg == S_IDLE);
    assign out_item.valid      = (state_reg == S_OUT_WAIT);
    assign out_item.status     = o_status_reg;
    assign out_item.target_id  = o_target_reg;
    assign out_item.run_length = o_run_reg;
    assign out_item.truncated  = o_trunc_reg;
    assign out_item.last       = o_last_reg;

    `SAT_ASSERT_SAME(a_no_overlap, clk, rst_n, out_item.valid, !in_item.ready,
        "input taken while a result word is pending")
    `SAT_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(TABLE_DEPTH),
        "entry count beyond table depth")
    `SAT_ASSERT_SAME(a_single_last, clk, rst_n,
        out_item.valid && out_item.status != ST_AMBIG, out_item.last,
        "non-ambiguous result without last")
    `SAT_ASSERT_NEXT(a_count_step, clk, rst_n, state_reg != S_SHIFT_CHK,
        count_reg == $past(count_reg), "entry count changed outside an insert")
endmodule

FILE: rtl/sat_cmp.sv
module sat_cmp (
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        lt,
    output logic        eq
);
    assign lt = (a < b);
    assign eq = (a == b);
endmodule

FILE: rtl/sat_table.sv
module sat_table #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output sat_pkg::entry_t   rd_data,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  sat_pkg::entry_t   wr_data
);
    import sat_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule
